// File: rtl/pfa_pkg.sv
package pfa_pkg;

  localparam int FIELD_W   = 32;
  localparam int OBJ_IN_N  = 4;
  localparam int CNT_W     = 9;
  localparam int NOBJ_W    = 3;
  localparam int APB_W     = 32;
  localparam int PADDR_W   = 3;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam logic [0:0] REG_NUM_OBJ = 1'b0;

  localparam logic [NOBJ_W-1:0] NUM_OBJ_RESET = 3'd2;

  typedef struct packed {
    logic new_le;
    logic cur_le;
  } pfa_dom_t;

endpackage

// File: rtl/pfa_cfg.sv
module pfa_cfg
  import pfa_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [APB_W-1:0]         pwdata,
  output logic [APB_W-1:0]         prdata,
  output logic                     pready,
  output logic [NOBJ_W-1:0]        num_obj
);

  logic [NOBJ_W-1:0] num_obj_r;
  logic              hit;

  assign hit    = (paddr[PADDR_W-1] == REG_NUM_OBJ);
  assign pready = 1'b1;
  assign prdata = hit ? APB_W'(num_obj_r) : '0;
  assign num_obj = num_obj_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_obj_r <= NUM_OBJ_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      num_obj_r <= pwdata[NOBJ_W-1:0];
    end
  end

endmodule

// File: rtl/pfa_table.sv
module pfa_table
  import pfa_pkg::*;
#(
  parameter int DEPTH  = 256,
  parameter int DATA_W = 129
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/pfa_dom.sv
module pfa_dom
  import pfa_pkg::*;
#(
  parameter int NOBJ = 4,
  parameter int EW   = 32
) (
  input  logic [NOBJ-1:0][EW-1:0] key,
  input  logic [NOBJ-1:0][EW-1:0] ent,
  input  logic [NOBJ_W-1:0]       nobj,
  output pfa_dom_t                dom
);

  always_comb begin
    dom.new_le = 1'b1;
    dom.cur_le = 1'b1;
    for (int k = 0; k < NOBJ; k++) begin
      if (k < int'(nobj)) begin
        if ($signed(ent[k]) < $signed(key[k])) begin
          dom.new_le = 1'b0;
        end
        if ($signed(key[k]) < $signed(ent[k])) begin
          dom.cur_le = 1'b0;
        end
      end
    end
  end

endmodule

// File: rtl/pareto_front_archive.sv
// Archive of non-dominated objective vectors (minimization) held in one single-port-read table.
// After reset the table is cleared one slot per cycle, with busy high until the last slot is cleared;
// configuration writes are taken during that time. An item is accepted when start is high and
// busy is low. An insert scans every slot through the table's one read port, one slot per cycle
// with all objectives compared at once, and then writes back: its result is registered from the
// WRITE state. A read passes through the READ state, and its result is registered from there.
// Each result is shown for exactly one cycle with out_valid high and must be taken then, since
// the receiver cannot stall the block. Busy is low in the result cycle, so the next item may be
// accepted in that same cycle.
module pareto_front_archive
  import pfa_pkg::*;
#(
  parameter int CAPACITY  = 256,
  parameter int MAX_OBJ   = 4,
  parameter int OBJ_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_cmd,
  input  logic [7:0]                in_slot_index,
  input  logic signed [FIELD_W-1:0] in_obj_0,
  input  logic signed [FIELD_W-1:0] in_obj_1,
  input  logic signed [FIELD_W-1:0] in_obj_2,
  input  logic signed [FIELD_W-1:0] in_obj_3,
  output logic                      out_valid,
  output logic                      out_non_dominated,
  output logic                      out_stored,
  output logic                      out_overflow,
  output logic [CNT_W-1:0]          out_evicted_count,
  output logic [CNT_W-1:0]          out_entry_total,
  output logic                      out_slot_valid,
  output logic signed [FIELD_W-1:0] out_rd_obj_0,
  output logic signed [FIELD_W-1:0] out_rd_obj_1,
  output logic signed [FIELD_W-1:0] out_rd_obj_2,
  output logic signed [FIELD_W-1:0] out_rd_obj_3,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [APB_W-1:0]          pwdata,
  output logic [APB_W-1:0]          prdata,
  output logic                      pready
);

  localparam int EW    = (OBJ_WIDTH > FIELD_W) ? FIELD_W : OBJ_WIDTH;
  localparam int NOBJ  = (MAX_OBJ > OBJ_IN_N) ? OBJ_IN_N : MAX_OBJ;
  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int ENT_W = 1 + NOBJ * EW;
  localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_WRITE = 5'b10000
  } state_t;

  typedef logic [NOBJ-1:0][EW-1:0] objs_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       ptr_r, ptr_nxt;
  objs_t               key_r, key_nxt;
  logic [NOBJ_W-1:0]   nobj_r, nobj_nxt;
  logic [CNT_W-1:0]    evict_r, evict_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                dom_r, dom_nxt;
  logic                free_found_r, free_found_nxt;
  logic [AW-1:0]       free_slot_r, free_slot_nxt;
  logic                rd_ok_r, rd_ok_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   nd_r, nd_nxt;
  logic                   stored_r, stored_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [CNT_W-1:0]       evc_r, evc_nxt;
  logic [CNT_W-1:0]       total_r, total_nxt;
  logic                   sv_r, sv_nxt;
  logic [OBJ_IN_N-1:0][FIELD_W-1:0] rdo_r, rdo_nxt;

  logic [NOBJ_W-1:0]   num_obj;
  logic [NOBJ_W-1:0]   nobj_act;
  logic                accept;
  logic                slot_in_range;
  logic [OBJ_IN_N-1:0][FIELD_W-1:0] in_objs;
  objs_t               in_key;

  logic                rd_en, wr_en;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic [ENT_W-1:0]    rd_data, wr_data;
  logic                ent_valid;
  objs_t               ent_objs;
  logic [OBJ_IN_N-1:0][FIELD_W-1:0] ent_ext;
  pfa_dom_t            dom;

  pfa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .num_obj (num_obj)
  );

  pfa_table #(
    .DEPTH  (CAPACITY),
    .DATA_W (ENT_W)
  ) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  pfa_dom #(
    .NOBJ (NOBJ),
    .EW   (EW)
  ) u_dom (
    .key  (key_r),
    .ent  (ent_objs),
    .nobj (nobj_r),
    .dom  (dom)
  );

  assign in_objs       = {in_obj_3, in_obj_2, in_obj_1, in_obj_0};
  assign accept        = start && (state_r == ST_IDLE);
  assign busy          = (state_r != ST_IDLE);
  assign slot_in_range = (int'(in_slot_index) < CAPACITY);
  assign ent_valid     = rd_data[ENT_W-1];
  assign ent_objs      = objs_t'(rd_data[NOBJ*EW-1:0]);

  always_comb begin
    for (int k = 0; k < NOBJ; k++) begin
      in_key[k] = in_objs[k][EW-1:0];
    end
  end

  always_comb begin
    logic signed [EW-1:0] v;
    for (int k = 0; k < OBJ_IN_N; k++) begin
      ent_ext[k] = '0;
      if (k < NOBJ) begin
        v = $signed(ent_objs[k]);
        ent_ext[k] = FIELD_W'(v);
      end
    end
  end

  always_comb begin
    nobj_act = num_obj;
    if (num_obj == '0) begin
      nobj_act = NOBJ_W'(1);
    end else if (int'(num_obj) > NOBJ) begin
      nobj_act = NOBJ_W'(NOBJ);
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr_r + 1'b1;
    wr_en   = 1'b0;
    wr_addr = ptr_r;
    wr_data = '0;
    unique case (state_r)
      ST_CLEAR: begin
        wr_en = 1'b1;
      end
      ST_IDLE: begin
        if (in_cmd == CMD_READ) begin
          rd_en   = start && slot_in_range;
          rd_addr = AW'(in_slot_index);
        end else begin
          rd_en   = start;
          rd_addr = '0;
        end
      end
      ST_READ: begin
      end
      ST_SCAN: begin
        rd_en   = (ptr_r != LAST);
        wr_en   = ent_valid && dom.new_le;
        wr_data = {1'b0, rd_data[NOBJ*EW-1:0]};
      end
      ST_WRITE: begin
        wr_en   = !dom_r && free_found_r;
        wr_addr = free_slot_r;
        wr_data = {1'b1, key_r};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    logic evict;
    evict          = 1'b0;
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    key_nxt        = key_r;
    nobj_nxt       = nobj_r;
    evict_nxt      = evict_r;
    count_nxt      = count_r;
    dom_nxt        = dom_r;
    free_found_nxt = free_found_r;
    free_slot_nxt  = free_slot_r;
    rd_ok_nxt      = rd_ok_r;
    out_valid_nxt  = 1'b0;
    nd_nxt         = nd_r;
    stored_nxt     = stored_r;
    ovf_nxt        = ovf_r;
    evc_nxt        = evc_r;
    total_nxt      = total_r;
    sv_nxt         = sv_r;
    rdo_nxt        = rdo_r;
    unique case (state_r)
      ST_CLEAR: begin
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == LAST) begin
          ptr_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_READ) begin
            rd_ok_nxt = slot_in_range;
            state_nxt = ST_READ;
          end else begin
            key_nxt        = in_key;
            nobj_nxt       = nobj_act;
            evict_nxt      = '0;
            dom_nxt        = 1'b0;
            free_found_nxt = 1'b0;
            free_slot_nxt  = '0;
            ptr_nxt        = '0;
            state_nxt      = ST_SCAN;
          end
        end
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        nd_nxt        = 1'b0;
        stored_nxt    = 1'b0;
        ovf_nxt       = 1'b0;
        evc_nxt       = '0;
        total_nxt     = CNT_W'(count_r);
        sv_nxt        = rd_ok_r && ent_valid;
        rdo_nxt       = (rd_ok_r && ent_valid) ? ent_ext : '0;
        state_nxt     = ST_IDLE;
      end
      ST_SCAN: begin
        evict = ent_valid && dom.new_le;
        if (evict) begin
          evict_nxt = evict_r + 1'b1;
          if (count_r != '0) begin
            count_nxt = count_r - 1'b1;
          end
        end else if (ent_valid && dom.cur_le) begin
          dom_nxt = 1'b1;
        end
        if ((!ent_valid || evict) && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_slot_nxt  = ptr_r;
        end
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == LAST) begin
          ptr_nxt   = '0;
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        out_valid_nxt = 1'b1;
        nd_nxt        = !dom_r;
        stored_nxt    = !dom_r && free_found_r;
        ovf_nxt       = !dom_r && !free_found_r;
        evc_nxt       = evict_r;
        sv_nxt        = 1'b0;
        rdo_nxt       = '0;
        if (!dom_r && free_found_r) begin
          count_nxt = count_r + 1'b1;
        end
        total_nxt = CNT_W'(count_nxt);
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ptr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    nobj_r       <= nobj_nxt;
    evict_r      <= evict_nxt;
    dom_r        <= dom_nxt;
    free_found_r <= free_found_nxt;
    free_slot_r  <= free_slot_nxt;
    rd_ok_r      <= rd_ok_nxt;
    nd_r         <= nd_nxt;
    stored_r     <= stored_nxt;
    ovf_r        <= ovf_nxt;
    evc_r        <= evc_nxt;
    total_r      <= total_nxt;
    sv_r         <= sv_nxt;
    rdo_r        <= rdo_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_non_dominated = nd_r;
  assign out_stored        = stored_r;
  assign out_overflow      = ovf_r;
  assign out_evicted_count = evc_r;
  assign out_entry_total   = total_r;
  assign out_slot_valid    = sv_r;
  assign out_rd_obj_0      = rdo_r[0];
  assign out_rd_obj_1      = rdo_r[1];
  assign out_rd_obj_2      = rdo_r[2];
  assign out_rd_obj_3      = rdo_r[3];

endmodule

// File: sim/testbench.sv
module testbench;
  import pfa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 256;
  localparam int OBJ_LIMIT = 4;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int FILL_ITEMS = 320;
  localparam int PHASE_ITEMS = 60;
  localparam logic [PADDR_W-1:0] NUM_OBJ_ADDR = PADDR_W'(4 * REG_NUM_OBJ);
  localparam logic signed [FIELD_W-1:0] OBJ_MIN = 32'sh8000_0000;
  localparam logic signed [FIELD_W-1:0] OBJ_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic cmd;
    logic [7:0] slot;
    logic signed [FIELD_W-1:0] obj [OBJ_IN_N];
  } archive_item_t;

  typedef struct {
    logic non_dominated;
    logic stored;
    logic overflow;
    logic [CNT_W-1:0] evicted;
    logic [CNT_W-1:0] total;
    logic slot_valid;
    logic signed [FIELD_W-1:0] rd [OBJ_IN_N];
  } archive_result_t;

  class archive_scoreboard;
    logic signed [FIELD_W-1:0] front [TABLE_DEPTH][OBJ_IN_N];
    bit occupied [TABLE_DEPTH];
    int entries;
    int unsigned num_obj;
    int errors;
    archive_result_t expected_q [$];

    function new();
      foreach (occupied[s]) occupied[s] = 1'b0;
      entries = 0;
      num_obj = NUM_OBJ_RESET;
      errors = 0;
    endfunction

    function void set_objectives(logic [NOBJ_W-1:0] value);
      num_obj = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_item(archive_item_t it);
      archive_result_t r;
      int n;
      int evicted;
      bit dominated;
      bit new_le;
      bit cur_le;
      bit slot_found;
      r.non_dominated = 1'b0;
      r.stored = 1'b0;
      r.overflow = 1'b0;
      r.evicted = '0;
      r.slot_valid = 1'b0;
      foreach (r.rd[k]) r.rd[k] = '0;
      if (it.cmd == CMD_READ) begin
        if (occupied[it.slot]) begin
          r.slot_valid = 1'b1;
          foreach (r.rd[k]) r.rd[k] = front[it.slot][k];
        end
      end else begin
        n = (num_obj == 0) ? 1 : (num_obj > OBJ_LIMIT) ? OBJ_LIMIT : int'(num_obj);
        dominated = 1'b0;
        evicted = 0;
        for (int s = 0; s < TABLE_DEPTH; s++) begin
          if (occupied[s]) begin
            new_le = 1'b1;
            cur_le = 1'b1;
            for (int k = 0; k < n; k++) begin
              if (front[s][k] < it.obj[k]) new_le = 1'b0;
              if (it.obj[k] < front[s][k]) cur_le = 1'b0;
            end
            if (new_le) begin
              occupied[s] = 1'b0;
              entries--;
              evicted++;
            end else if (cur_le) begin
              dominated = 1'b1;
            end
          end
        end
        if (!dominated) begin
          r.non_dominated = 1'b1;
          if (entries < TABLE_DEPTH) begin
            slot_found = 1'b0;
            for (int s = 0; s < TABLE_DEPTH && !slot_found; s++) begin
              if (!occupied[s]) begin
                foreach (it.obj[k]) front[s][k] = it.obj[k];
                occupied[s] = 1'b1;
                slot_found = 1'b1;
              end
            end
            entries++;
            r.stored = 1'b1;
          end else begin
            r.overflow = 1'b1;
          end
        end
        r.evicted = CNT_W'(evicted);
      end
      r.total = CNT_W'(entries);
      expected_q.push_back(r);
    endfunction

    function void compare(string name, logic signed [63:0] want, logic signed [63:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0d, got %0d", name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(archive_result_t got);
      archive_result_t want;
      if (expected_q.size() == 0) begin
        $error("Result arrived with no item outstanding.");
        errors++;
      end else begin
        want = expected_q.pop_front();
        compare("non_dominated", want.non_dominated, got.non_dominated);
        compare("stored", want.stored, got.stored);
        compare("overflow", want.overflow, got.overflow);
        compare("evicted_count", want.evicted, got.evicted);
        compare("entry_total", want.total, got.total);
        compare("slot_valid", want.slot_valid, got.slot_valid);
        foreach (want.rd[k]) compare($sformatf("rd_obj_%0d", k), want.rd[k], got.rd[k]);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_cmd = CMD_INSERT;
  logic [7:0] in_slot_index = '0;
  logic signed [FIELD_W-1:0] in_obj_0 = '0;
  logic signed [FIELD_W-1:0] in_obj_1 = '0;
  logic signed [FIELD_W-1:0] in_obj_2 = '0;
  logic signed [FIELD_W-1:0] in_obj_3 = '0;
  logic out_valid;
  logic out_non_dominated;
  logic out_stored;
  logic out_overflow;
  logic [CNT_W-1:0] out_evicted_count;
  logic [CNT_W-1:0] out_entry_total;
  logic out_slot_valid;
  logic signed [FIELD_W-1:0] out_rd_obj_0;
  logic signed [FIELD_W-1:0] out_rd_obj_1;
  logic signed [FIELD_W-1:0] out_rd_obj_2;
  logic signed [FIELD_W-1:0] out_rd_obj_3;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [APB_W-1:0] pwdata = '0;
  logic [APB_W-1:0] prdata;
  logic pready;

  archive_scoreboard sb;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int unsigned cycle_count = 0;

  pareto_front_archive #(
    .CAPACITY(TABLE_DEPTH),
    .MAX_OBJ(OBJ_LIMIT),
    .OBJ_WIDTH(FIELD_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_cmd(in_cmd),
    .in_slot_index(in_slot_index),
    .in_obj_0(in_obj_0),
    .in_obj_1(in_obj_1),
    .in_obj_2(in_obj_2),
    .in_obj_3(in_obj_3),
    .out_valid(out_valid),
    .out_non_dominated(out_non_dominated),
    .out_stored(out_stored),
    .out_overflow(out_overflow),
    .out_evicted_count(out_evicted_count),
    .out_entry_total(out_entry_total),
    .out_slot_valid(out_slot_valid),
    .out_rd_obj_0(out_rd_obj_0),
    .out_rd_obj_1(out_rd_obj_1),
    .out_rd_obj_2(out_rd_obj_2),
    .out_rd_obj_3(out_rd_obj_3),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    archive_result_t got;
    if (rst_n && out_valid) begin
      got.non_dominated = out_non_dominated;
      got.stored = out_stored;
      got.overflow = out_overflow;
      got.evicted = out_evicted_count;
      got.total = out_entry_total;
      got.slot_valid = out_slot_valid;
      got.rd[0] = out_rd_obj_0;
      got.rd[1] = out_rd_obj_1;
      got.rd[2] = out_rd_obj_2;
      got.rd[3] = out_rd_obj_3;
      sb.check_result(got);
    end
  end

  function automatic archive_item_t make_insert(logic signed [FIELD_W-1:0] a,
                                                logic signed [FIELD_W-1:0] b,
                                                logic signed [FIELD_W-1:0] c,
                                                logic signed [FIELD_W-1:0] d);
    archive_item_t it;
    it.cmd = CMD_INSERT;
    it.slot = 8'($urandom);
    it.obj[0] = a;
    it.obj[1] = b;
    it.obj[2] = c;
    it.obj[3] = d;
    return it;
  endfunction

  function automatic archive_item_t make_read(logic [7:0] slot);
    archive_item_t it;
    it.cmd = CMD_READ;
    it.slot = slot;
    foreach (it.obj[k]) it.obj[k] = $urandom;
    return it;
  endfunction

  function automatic archive_item_t random_read();
    int top;
    top = (sb.entries < 255) ? sb.entries + 1 : 255;
    if ($urandom_range(0, 3) == 0) return make_read(8'($urandom_range(0, 255)));
    return make_read(8'($urandom_range(0, top)));
  endfunction

  // Small values make ties and repeated vectors common; full-range values toggle every bit.
  function automatic logic signed [FIELD_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0, 1: return $urandom;
      2: return int'($urandom_range(0, 7)) - 4;
      default: begin
        case ($urandom_range(0, 3))
          0: return OBJ_MIN;
          1: return OBJ_MAX;
          2: return '0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  task automatic send_item(archive_item_t it);
    start <= 1'b1;
    in_cmd <= it.cmd;
    in_slot_index <= it.slot;
    in_obj_0 <= it.obj[0];
    in_obj_1 <= it.obj[1];
    in_obj_2 <= it.obj[2];
    in_obj_3 <= it.obj[3];
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_item(it);
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 300) : $urandom_range(0, 4);
      if (gaps_on && gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [PADDR_W-1:0] addr, logic [APB_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_objectives(data[NOBJ_W-1:0]);
  endtask

  task automatic run_item(archive_item_t it);
    send_item(it);
    pace();
  endtask

  task automatic directed_items();
    run_item(make_read(8'd0));
    run_item(make_read(8'd255));
    run_item(make_insert(OBJ_MAX, OBJ_MAX, OBJ_MIN, OBJ_MIN));
    run_item(make_insert(OBJ_MAX, OBJ_MAX, 5, -5));
    run_item(make_read(8'd0));
    run_item(make_insert(OBJ_MIN, OBJ_MAX, 1, 2));
    run_item(make_insert(OBJ_MAX, OBJ_MIN, 3, 4));
    run_item(make_insert(0, OBJ_MAX, 0, 0));
    run_item(make_insert(-1, -1, OBJ_MAX, OBJ_MIN));
    run_item(make_read(8'd1));
    run_item(make_read(8'd2));
    // With one objective, this evicts one entry and is beaten by the others.
    wait_all_results();
    write_reg(NUM_OBJ_ADDR, 1);
    run_item(make_insert(0, 0, 0, 0));
    run_item(make_read(8'd1));
    wait_all_results();
    write_reg(NUM_OBJ_ADDR, OBJ_LIMIT);
    run_item(make_insert(OBJ_MIN, OBJ_MIN, OBJ_MIN, OBJ_MIN));
    run_item(make_insert(OBJ_MAX, OBJ_MAX, OBJ_MAX, OBJ_MAX));
    run_item(make_insert(OBJ_MIN, OBJ_MIN, OBJ_MIN, OBJ_MIN));
    run_item(make_read(8'd0));
    run_item(make_read(8'd3));
    run_item(make_insert(OBJ_MIN, OBJ_MIN, OBJ_MIN, OBJ_MAX));
    run_item(make_read(8'd0));
  endtask

  task automatic random_phase(int unsigned objectives, int count);
    wait_all_results();
    write_reg(NUM_OBJ_ADDR, objectives);
    gaps_on = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        run_item(make_insert(pick_value(), pick_value(), pick_value(), pick_value()));
      end else begin
        run_item(random_read());
      end
    end
  endtask

  // Distinct vectors on the line obj_1 = ~obj_0 never dominate each other, so the table fills up.
  task automatic fill_phase();
    logic signed [FIELD_W-1:0] x;
    wait_all_results();
    write_reg(NUM_OBJ_ADDR, 1);
    run_item(make_insert(OBJ_MIN, OBJ_MAX, $urandom, $urandom));
    wait_all_results();
    write_reg(NUM_OBJ_ADDR, 2);
    gaps_on = 1'b1;
    for (int i = 0; i < FILL_ITEMS; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        run_item(random_read());
      end else begin
        x = $urandom;
        run_item(make_insert(x, ~x, $urandom, $urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_items();
    random_phase(3, PHASE_ITEMS);
    random_phase(0, PHASE_ITEMS);
    random_phase(7, PHASE_ITEMS);
    fill_phase();
    random_phase(5, PHASE_ITEMS);
    random_phase(6, PHASE_ITEMS);
    random_phase(OBJ_LIMIT, PHASE_ITEMS);
    random_phase(2, PHASE_ITEMS);
    wait_all_results();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
